// ===== design/assert_macros.svh =====
// Concurrent assertion helpers, compiled out with NO_ASSERTIONS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)

`define ASSERT_NEVER(name, clk, rst_n, expr, msg)

`endif

`endif

// ===== design/cmdtok_pkg.sv =====
`default_nettype none

package cmdtok_pkg;

  localparam int unsigned DefMaxTokens    = 3;
  localparam int unsigned DefMaxHexDigits = 4;
  localparam int unsigned QueueDepth      = 2;

  localparam int unsigned KwCount  = 3;
  localparam int unsigned AccWidth = 21;
  localparam int unsigned PosWidth = 4;

  localparam logic [PosWidth-1:0] PosMax = 4'd15;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChLowA1 = 8'h60;
  localparam logic [7:0] OffLow  = 8'd87;
  localparam logic [7:0] OffUp   = 8'd55;

  typedef enum logic [1:0] {
    KIND_KEYWORD = 2'd0,
    KIND_NUMBER  = 2'd1,
    KIND_STRING  = 2'd2
  } cmdtok_kind_e;

  typedef enum logic [1:0] {
    KW_LOAD  = 2'd0,
    KW_STORE = 2'd1,
    KW_RESET = 2'd2
  } cmdtok_kw_e;

  localparam logic [39:0] KwText [KwCount] = '{
    {"load", 8'h00},
    "store",
    "reset"
  };

  localparam logic [PosWidth-1:0] KwLen [KwCount] = '{4'd4, 4'd5, 4'd5};

  typedef struct packed {
    logic                token_valid;
    logic [1:0]          token_index;
    logic [1:0]          token_kind;
    logic [1:0]          keyword_code;
    logic [AccWidth-1:0] number_value;
    logic                end_of_message;
    logic [1:0]          tokens_found;
  } cmdtok_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdtok_qstat_t;

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [PosWidth-1:0] p);
    logic [39:0] t;
    t = KwText[k];
    if (p < KwLen[k]) begin
      kw_char = t[8*(4-int'(p)) +: 8];
    end else begin
      kw_char = ChNul;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/cmdtok_intf.sv =====
`default_nettype none

interface cmdtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;

  modport source (output valid, output message_byte, input ready);
  modport sink   (input valid, input message_byte, output ready);
endinterface

interface cmdtok_out_if;
  logic        valid;
  logic        ready;
  logic        token_valid;
  logic [1:0]  token_index;
  logic [1:0]  token_kind;
  logic [1:0]  keyword_code;
  logic [20:0] number_value;
  logic        end_of_message;
  logic [1:0]  tokens_found;

  modport source (output valid, output token_valid, output token_index, output token_kind,
                  output keyword_code, output number_value, output end_of_message,
                  output tokens_found, input ready);
  modport sink   (input valid, input token_valid, input token_index, input token_kind,
                  input keyword_code, input number_value, input end_of_message,
                  input tokens_found, output ready);
endinterface

`default_nettype wire

// ===== design/cmdtok_front.sv =====
`default_nettype none

module cmdtok_front #(
  parameter int unsigned MAX_TOKENS     = cmdtok_pkg::DefMaxTokens,
  parameter int unsigned MAX_HEX_DIGITS = cmdtok_pkg::DefMaxHexDigits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  cmdtok_in_if.sink                       cmd_i,
  input  wire cmdtok_pkg::cmdtok_qstat_t  q_stat_i,
  output logic                            q_push_o,
  output cmdtok_pkg::cmdtok_result_t      q_data_o
);
  import cmdtok_pkg::*;

  localparam logic [1:0]          MaxTok = 2'(MAX_TOKENS);
  localparam logic [PosWidth-1:0] HexEnd = PosWidth'(2 + MAX_HEX_DIGITS);

  logic                inside_q, inside_d;
  logic [1:0]          count_q, count_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [KwCount-1:0]  flags_q, flags_d;
  logic [AccWidth-1:0] acc_q, acc_d;
  logic                hexok_q, hexok_d;

  logic                accept, is_nul, is_space, start, take;
  logic [PosWidth-1:0] p_eff;
  logic [KwCount-1:0]  flags_eff, flags_new;
  logic [AccWidth-1:0] acc_eff, acc_new;
  logic                hexok_eff, hexok_new;
  logic [7:0]          b, digit;
  logic                kw_hit;
  logic [1:0]          kw_code;
  cmdtok_result_t      res;

  assign cmd_i.ready = !q_stat_i.full;
  assign accept      = cmd_i.valid && !q_stat_i.full;
  assign b           = cmd_i.message_byte;
  assign is_nul      = (b == ChNul);
  assign is_space    = (b == ChSpace);
  assign start       = !is_nul && !is_space && !inside_q && (count_q < MaxTok);
  assign take        = !is_nul && !is_space && (inside_q || start);

  // Character step, starting from fresh token state when a token opens.
  always_comb begin
    p_eff     = start ? '0 : pos_q;
    flags_eff = start ? '1 : flags_q;
    acc_eff   = start ? '0 : acc_q;
    hexok_eff = start ? 1'b1 : hexok_q;

    for (int unsigned k = 0; k < KwCount; k++) begin
      flags_new[k] = flags_eff[k] && (p_eff < KwLen[k]) && (kw_char(k, p_eff) == b);
    end

    if (b > ChLowA1) begin
      digit = b - OffLow;
    end else if (b > ChAt) begin
      digit = b - OffUp;
    end else begin
      digit = b - ChZero;
    end

    hexok_new = hexok_eff;
    acc_new   = acc_eff;
    if (p_eff == 4'd0) begin
      if (b != ChZero) hexok_new = 1'b0;
    end else if (p_eff == 4'd1) begin
      if (b != ChX) hexok_new = 1'b0;
    end else if (p_eff >= HexEnd) begin
      hexok_new = 1'b0;
    end else begin
      acc_new = {acc_eff[AccWidth-5:0], 4'b0000} + AccWidth'(digit);
    end
  end

  // Classification of the open token.
  always_comb begin
    kw_hit  = 1'b0;
    kw_code = KW_LOAD;
    for (int k = KwCount - 1; k >= 0; k--) begin
      if (flags_q[k] && (pos_q == KwLen[k])) begin
        kw_hit  = 1'b1;
        kw_code = 2'(k);
      end
    end

    res                = '0;
    res.end_of_message = is_nul;
    res.tokens_found   = count_q;
    if (inside_q) begin
      res.token_valid = 1'b1;
      res.token_index = count_q - 2'd1;
      if (kw_hit) begin
        res.token_kind   = KIND_KEYWORD;
        res.keyword_code = kw_code;
      end else if (hexok_q && (pos_q >= 4'd3)) begin
        res.token_kind   = KIND_NUMBER;
        res.number_value = acc_q;
      end else begin
        res.token_kind = KIND_STRING;
      end
    end
  end

  assign q_push_o = accept && (is_nul || (is_space && inside_q));
  assign q_data_o = res;

  always_comb begin
    inside_d = inside_q;
    count_d  = count_q;
    pos_d    = pos_q;
    flags_d  = flags_q;
    acc_d    = acc_q;
    hexok_d  = hexok_q;
    if (accept) begin
      if (is_nul || (is_space && inside_q)) begin
        inside_d = 1'b0;
        pos_d    = '0;
        flags_d  = '1;
        acc_d    = '0;
        hexok_d  = 1'b1;
        if (is_nul) count_d = '0;
      end else if (take) begin
        inside_d = 1'b1;
        count_d  = start ? count_q + 2'd1 : count_q;
        pos_d    = (p_eff < PosMax) ? p_eff + 4'd1 : p_eff;
        flags_d  = flags_new;
        acc_d    = acc_new;
        hexok_d  = hexok_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      count_q  <= '0;
      pos_q    <= '0;
      flags_q  <= '1;
      acc_q    <= '0;
      hexok_q  <= 1'b1;
    end else begin
      inside_q <= inside_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      flags_q  <= flags_d;
      acc_q    <= acc_d;
      hexok_q  <= hexok_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/cmdtok_fifo.sv =====
`default_nettype none

module cmdtok_fifo (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire cmdtok_pkg::cmdtok_result_t  push_data_i,
  input  wire logic                        pop_i,
  output cmdtok_pkg::cmdtok_result_t       pop_data_o,
  output cmdtok_pkg::cmdtok_qstat_t        stat_o
);
  import cmdtok_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  cmdtok_result_t  slots_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = slots_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == LastPtr) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = do_pop  ? ((rd_q == LastPtr) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/cmdtok_back.sv =====
`default_nettype none

module cmdtok_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cmdtok_pkg::cmdtok_qstat_t   q_stat_i,
  input  wire cmdtok_pkg::cmdtok_result_t  q_data_i,
  output logic                             q_pop_o,
  cmdtok_out_if.source                     tok_o
);
  import cmdtok_pkg::*;

  logic           valid_q, valid_d;
  cmdtok_result_t beat_q;
  logic           load;

  assign load    = !q_stat_i.empty && (!valid_q || tok_o.ready);
  assign q_pop_o = load;
  assign valid_d = load ? 1'b1 : (valid_q && !tok_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) beat_q <= q_data_i;
  end

  assign tok_o.valid          = valid_q;
  assign tok_o.token_valid    = beat_q.token_valid;
  assign tok_o.token_index    = beat_q.token_index;
  assign tok_o.token_kind     = beat_q.token_kind;
  assign tok_o.keyword_code   = beat_q.keyword_code;
  assign tok_o.number_value   = beat_q.number_value;
  assign tok_o.end_of_message = beat_q.end_of_message;
  assign tok_o.tokens_found   = beat_q.tokens_found;

endmodule

`default_nettype wire

// ===== design/command_token_classifier_unit.sv =====
`default_nettype none

`include "assert_macros.svh"

// Command token classifier. Takes a message one byte per beat on cmd_i; a space
// closes a token and a zero byte ends the message. Each of the first MAX_TOKENS
// tokens is reported on tok_o when it closes, as a keyword (load, store, reset),
// a hex number ("0x" plus 1 to MAX_HEX_DIGITS digits, digits not checked) or a
// string; the zero byte always gives one end beat. A byte is accepted every
// cycle as long as the two-entry result queue has room; results reach tok_o
// from the byte that closes the token through the queue and then the output
// register. Only a stalled tok_o slows the input, once the queue fills.
module command_token_classifier_unit #(
  parameter int unsigned MAX_TOKENS     = cmdtok_pkg::DefMaxTokens,
  parameter int unsigned MAX_HEX_DIGITS = cmdtok_pkg::DefMaxHexDigits
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  cmdtok_in_if.sink     cmd_i,
  cmdtok_out_if.source  tok_o
);
  import cmdtok_pkg::*;

  localparam logic [1:0] MaxTok = 2'(MAX_TOKENS);

  cmdtok_qstat_t  q_stat;
  cmdtok_result_t push_data, pop_data;
  logic           q_push, q_pop;

  cmdtok_front #(
    .MAX_TOKENS     (MAX_TOKENS),
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_data_o (push_data)
  );

  cmdtok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  cmdtok_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .q_data_i (pop_data),
    .q_pop_o  (q_pop),
    .tok_o    (tok_o)
  );

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, q_push && q_stat.full, "push into full queue")
  `ASSERT_PROP(a_bare_is_end, clk_i, rst_ni, (tok_o.valid && !tok_o.token_valid) |-> tok_o.end_of_message, "beat without token is not end of message")
  `ASSERT_PROP(a_index_range, clk_i, rst_ni, (tok_o.valid && tok_o.token_valid) |-> (tok_o.token_index < MaxTok), "token index out of range")
  `ASSERT_PROP(a_found_match, clk_i, rst_ni, (tok_o.valid && tok_o.token_valid) |-> (tok_o.tokens_found == tok_o.token_index + 2'd1), "token count does not match index")

endmodule

`default_nettype wire
